// ----- hdl/fmdm_pkg.sv -----
// Package for the FM sample to divider modulator: widths, register indexes,
// the quarter-wave sine table and the microcode program of the sequencer.
// No dependencies.
`default_nettype none

package fmdm_pkg;

  // Data widths of the ports
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_DATA_W = 80;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CENTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CPS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PREEMP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEVGN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd6;

  // Register reset values
  localparam logic [23:0]        CENTER_RST = 24'd69207;
  localparam logic [15:0]        CPS_RST    = 16'd2834;
  localparam logic signed [23:0] PREEMP_RST = -24'sd19206;
  localparam logic [23:0]        DEVGN_RST  = 24'd884736;

  // Sine table: one cycle of SINE_TABLE_DEPTH points, stored as a quarter wave
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_AW          = $clog2(SINE_TABLE_DEPTH);
  localparam int QUARTER_AW       = SINE_AW - 2;
  localparam int QUARTER          = SINE_TABLE_DEPTH / 4;
  localparam int SINE_PEAK        = 32767;

  // Divider window
  localparam int DIVIDER_SPAN = 1024;
  localparam int N_W          = 23;
  localparam logic signed [N_W-1:0] N_LO = N_W'(1 - DIVIDER_SPAN / 2);
  localparam logic signed [N_W-1:0] N_HI = N_W'(DIVIDER_SPAN / 2 - 2);

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef logic [14:0] sine_lut_t [0:QUARTER];

  // sin(2*pi*m/DEPTH) for m in 0..DEPTH/4: quarter-wave Taylor series in Q30
  function automatic logic [14:0] sine_mag(input int unsigned m);
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] q;
    u    = (64'(m) << 32) / 64'(SINE_TABLE_DEPTH);
    x    = (u * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = Q30_ONE - x2 / 64'd72;
    term = Q30_ONE - ((x2 * term) >> 30) / 64'd42;
    term = Q30_ONE - ((x2 * term) >> 30) / 64'd20;
    term = Q30_ONE - ((x2 * term) >> 30) / 64'd6;
    s    = (x * term) >> 30;
    q    = (s + 64'd16384) >> 15;
    if (q > 64'(SINE_PEAK)) begin
      q = 64'(SINE_PEAK);
    end
    return q[14:0];
  endfunction

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int i = 0; i <= QUARTER; i++) begin
      lut[i] = sine_mag(i);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

  // Microcode
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_VOICE,
    MUL_TONE,
    MUL_PRE,
    MUL_DEV,
    MUL_HOLD
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_RND_T0,
    OP_RND_T1,
    OP_MIX,
    OP_DIFF,
    OP_YSUM,
    OP_DSUM,
    OP_MAG,
    OP_NRND,
    OP_REM,
    OP_CLAMP,
    OP_DIV,
    OP_OUT
  } alu_op_t;

  typedef enum logic {
    JMP_NONE,
    JMP_NCLIP
  } jmp_t;

  localparam int PC_W = 5;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_START = 5'd0;
  localparam pc_t PC_DIV   = 5'd15;
  localparam pc_t PC_LAST  = 5'd16;

  typedef struct packed {
    mul_sel_t mul;
    alu_op_t  op;
    jmp_t     jmp;
    pc_t      target;
    logic     last;
  } uword_t;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      5'd0:    w = '{MUL_VOICE, OP_NOP,    JMP_NONE,  PC_START, 1'b0};
      5'd1:    w = '{MUL_TONE,  OP_RND_T0, JMP_NONE,  PC_START, 1'b0};
      5'd2:    w = '{MUL_NONE,  OP_RND_T1, JMP_NONE,  PC_START, 1'b0};
      5'd3:    w = '{MUL_NONE,  OP_MIX,    JMP_NONE,  PC_START, 1'b0};
      5'd4:    w = '{MUL_NONE,  OP_DIFF,   JMP_NONE,  PC_START, 1'b0};
      5'd5:    w = '{MUL_PRE,   OP_NOP,    JMP_NONE,  PC_START, 1'b0};
      5'd6:    w = '{MUL_NONE,  OP_RND_T0, JMP_NONE,  PC_START, 1'b0};
      5'd7:    w = '{MUL_NONE,  OP_YSUM,   JMP_NONE,  PC_START, 1'b0};
      5'd8:    w = '{MUL_DEV,   OP_NOP,    JMP_NONE,  PC_START, 1'b0};
      5'd9:    w = '{MUL_NONE,  OP_DSUM,   JMP_NONE,  PC_START, 1'b0};
      5'd10:   w = '{MUL_NONE,  OP_MAG,    JMP_NONE,  PC_START, 1'b0};
      5'd11:   w = '{MUL_NONE,  OP_NRND,   JMP_NONE,  PC_START, 1'b0};
      5'd12:   w = '{MUL_NONE,  OP_REM,    JMP_NONE,  PC_START, 1'b0};
      5'd13:   w = '{MUL_NONE,  OP_NOP,    JMP_NCLIP, PC_DIV,   1'b0};
      5'd14:   w = '{MUL_NONE,  OP_CLAMP,  JMP_NONE,  PC_START, 1'b0};
      PC_DIV:  w = '{MUL_HOLD,  OP_DIV,    JMP_NONE,  PC_START, 1'b0};
      PC_LAST: w = '{MUL_NONE,  OP_OUT,    JMP_NONE,  PC_START, 1'b1};
      default: w = '{MUL_NONE,  OP_NOP,    JMP_NONE,  PC_START, 1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/fm_sample_to_divider_modulator.sv -----
// A new sample is accepted only while the sequencer is idle, so one sample is in flight at a time.
// Each sample runs the microcode program (16 steps, 17 with the clamp), which sends every
// product through one shared 33x26 multiplier. A finished result waits in the output register
// while the next sample runs; the last step stalls if that result has not yet been taken.
// Reset (rst_n, synchronous, active low) loads the register defaults, clears the
// pre-emphasis history and the tone phase; no clearing pass. Depends on fmdm_pkg.
`default_nettype none

module fm_sample_to_divider_modulator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel, tdata: audio_sample[15:0]
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [fmdm_pkg::SAMPLE_W-1:0]        in_tdata,
  // result channel, tdata: low_divider[23:0], low_hold[39:24],
  // high_divider[63:40], high_hold[79:64]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [fmdm_pkg::OUT_DATA_W-1:0]      out_tdata,
  // tuser: clipped[0]
  output logic [0:0]                           out_tuser,
  // configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [fmdm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fmdm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import fmdm_pkg::*;

  // Configuration
  logic [23:0]        center_r;
  logic [15:0]        cps_r;
  logic [15:0]        level_r;
  logic [19:0]        step_r;
  logic signed [23:0] preemp_r;
  logic [23:0]        devgn_r;
  logic signed [23:0] offset_r;

  // Item state
  logic signed [17:0] prev_r;
  logic [20:0]        phase_r;

  // Sequencer
  logic   busy_r, busy_nxt;
  pc_t    pc_r, pc_nxt;
  uword_t uw;
  logic   stall;
  logic   finish;
  logic   in_acc;
  logic   cfg_acc;

  // Datapath
  logic signed [15:0]  samp_r;
  logic signed [15:0]  sine_r;
  logic signed [58:0]  prod_r;
  logic signed [27:0]  t0_r;
  logic signed [16:0]  t1_r;
  logic signed [17:0]  mixed_r;
  logic signed [18:0]  diff_r;
  logic signed [27:0]  y_r;
  logic signed [52:0]  d_r;
  logic [52:0]         mag_r;
  logic                neg_r;
  logic signed [N_W-1:0] n_r;
  logic signed [31:0]  r_r;
  logic                clip_r;
  logic [23:0]         lo_div_r;
  logic [23:0]         hi_div_r;

  // Output register
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [23:0] out_lo_div_r;
  logic [15:0] out_lo_hold_r;
  logic [23:0] out_hi_div_r;
  logic [15:0] out_hi_hold_r;
  logic        out_clip_r;

  // Combinational helpers
  logic signed [32:0]  mul_a;
  logic signed [25:0]  mul_b;
  logic signed [58:0]  prod_full;
  logic signed [58:0]  rnd_full;
  logic signed [58:0]  rnd_sh;
  logic [16:0]         one_minus_level;
  logic [31:0]         frac;
  logic signed [52:0]  d_abs;
  logic [21:0]         n_mag;
  logic signed [52:0]  r_full;
  logic [15:0]         hh;
  logic [20:0]         phase_adv;

  logic [SINE_AW-1:0]    sine_k;
  logic [1:0]            sine_quad;
  logic [QUARTER_AW-1:0] sine_low;
  logic [QUARTER_AW:0]   sine_m;
  logic [14:0]           sine_mag_v;

  assign in_acc  = in_tvalid && in_tready;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;
  assign in_tready = !busy_r;

  assign uw     = ucode(pc_r);
  assign stall  = uw.last && out_tvalid_r && !out_tready;
  assign finish = busy_r && uw.last && !stall;

  // Sequencer next state
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    if (!busy_r) begin
      if (in_acc) begin
        busy_nxt = 1'b1;
        pc_nxt   = PC_START;
      end
    end else if (uw.last) begin
      if (!stall) begin
        busy_nxt = 1'b0;
        pc_nxt   = PC_START;
      end
    end else if (uw.jmp == JMP_NCLIP && !clip_r) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  assign out_tvalid_nxt = (out_tvalid_r && !out_tready) || finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      pc_r         <= PC_START;
      out_tvalid_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      pc_r         <= pc_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Configuration registers and item state
  assign phase_adv = phase_r[20] ? {1'b0, step_r} : phase_r + {1'b0, step_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= CENTER_RST;
      cps_r    <= CPS_RST;
      level_r  <= '0;
      step_r   <= '0;
      preemp_r <= PREEMP_RST;
      devgn_r  <= DEVGN_RST;
      offset_r <= '0;
      prev_r   <= '0;
      phase_r  <= '0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          REG_CENTER: center_r <= cfg_data;
          REG_CPS:    cps_r    <= cfg_data[15:0];
          REG_LEVEL:  level_r  <= cfg_data[15:0];
          REG_STEP: begin
            step_r  <= cfg_data[19:0];
            phase_r <= {1'b0, cfg_data[19:0]};
          end
          REG_PREEMP: preemp_r <= cfg_data;
          REG_DEVGN:  devgn_r  <= cfg_data;
          REG_OFFSET: offset_r <= cfg_data;
          default: ;
        endcase
      end else if (finish) begin
        prev_r  <= mixed_r;
        phase_r <= phase_adv;
      end
    end
  end

  // Sine lookup: fold the index onto the quarter wave
  assign sine_k     = phase_r[19 -: SINE_AW];
  assign sine_quad  = sine_k[SINE_AW-1 -: 2];
  assign sine_low   = sine_k[QUARTER_AW-1:0];
  assign sine_m     = sine_quad[0] ? (QUARTER_AW+1)'(QUARTER) - {1'b0, sine_low}
                                   : {1'b0, sine_low};
  assign sine_mag_v = SINE_LUT[sine_m];

  // Multiplier operand select
  assign one_minus_level = 17'h10000 - {1'b0, level_r};
  assign frac            = {~r_r[31], r_r[30:0]};

  always_comb begin
    case (uw.mul)
      MUL_VOICE: begin
        mul_a = 33'(samp_r);
        mul_b = signed'({9'b0, one_minus_level});
      end
      MUL_TONE: begin
        mul_a = signed'({17'b0, level_r});
        mul_b = 26'(sine_r);
      end
      MUL_PRE: begin
        mul_a = 33'(diff_r);
        mul_b = 26'(preemp_r);
      end
      MUL_DEV: begin
        mul_a = 33'(y_r);
        mul_b = signed'({2'b0, devgn_r});
      end
      MUL_HOLD: begin
        mul_a = signed'({1'b0, frac});
        mul_b = signed'({10'b0, cps_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  // Round half up to the Q.15 grid
  assign rnd_full = prod_r + 59'sd32768;
  assign rnd_sh   = rnd_full >>> 16;

  assign d_abs  = d_r[52] ? -d_r : d_r;
  assign n_mag  = mag_r[52:31];
  assign r_full = d_r - signed'(53'({n_r, 31'b0}));
  assign hh     = prod_r[47:32];

  // Datapath, driven by the control word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_r <= signed'(in_tdata);
      sine_r <= sine_quad[1] ? -signed'({1'b0, sine_mag_v}) : signed'({1'b0, sine_mag_v});
    end
    if (busy_r) begin
      if (uw.mul != MUL_NONE) begin
        prod_r <= prod_full;
      end
      case (uw.op)
        OP_RND_T0: t0_r    <= rnd_sh[27:0];
        OP_RND_T1: t1_r    <= rnd_sh[16:0];
        OP_MIX:    mixed_r <= 18'(t0_r) + 18'(t1_r);
        OP_DIFF:   diff_r  <= 19'(prev_r) - 19'(mixed_r);
        OP_YSUM:   y_r     <= 28'(mixed_r) + t0_r;
        OP_DSUM:   d_r     <= 53'(prod_r) + signed'({{14{offset_r[23]}}, offset_r, 15'b0});
        OP_MAG: begin
          neg_r <= d_r[52];
          mag_r <= d_abs + (53'd1 << 30);
        end
        OP_NRND:   n_r <= neg_r ? -signed'({1'b0, n_mag}) : signed'({1'b0, n_mag});
        OP_REM: begin
          r_r    <= r_full[31:0];
          clip_r <= (n_r < N_LO) || (n_r > N_HI);
        end
        OP_CLAMP: begin
          // saturate to the window edge, dither split falls to one half
          n_r <= n_r[N_W-1] ? N_LO : N_HI;
          r_r <= '0;
        end
        OP_DIV: begin
          lo_div_r <= center_r + 24'(n_r) - 24'd1;
          hi_div_r <= center_r + 24'(n_r) + 24'd1;
        end
        OP_OUT: begin
          if (!stall) begin
            out_lo_div_r  <= lo_div_r;
            out_hi_div_r  <= hi_div_r;
            out_hi_hold_r <= hh;
            out_lo_hold_r <= cps_r - hh;
            out_clip_r    <= clip_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_hi_hold_r, out_hi_div_r, out_lo_hold_r, out_lo_div_r};
  assign out_tuser  = out_clip_r;

  // Checks
  a_hold_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (16'(out_lo_hold_r + out_hi_hold_r) == cps_r))
    else $error("hold intervals do not add up to the sample period");

  a_div_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (24'(out_hi_div_r - out_lo_div_r) == 24'd2))
    else $error("divider words not two steps apart");

  a_clip_half: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_clip_r) |-> (out_hi_hold_r == (cps_r >> 1)))
    else $error("clipped result without an even split");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r <= PC_LAST))
    else $error("step counter ran past the program");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (busy_r && pc_r == PC_START))
    else $error("request taken without starting the program");

endmodule

`default_nettype wire
